### rtl/qfs_pkg.sv
package qfs_pkg;

  localparam int CHAR_WIDTH = 8;
  localparam int REG_SLOTS = 4;
  localparam int SLOTS_WIDTH = CHAR_WIDTH * REG_SLOTS;
  localparam int COUNT_WIDTH = 3;
  localparam int CHAR_SLOTS_DEFAULT = 4;

  localparam int CFG_INDEX_WIDTH = 3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SEPARATOR_SLOTS = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SEPARATOR_COUNT = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_QUOTE_SLOTS = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_QUOTE_COUNT = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_COMMENT_SLOTS = 3'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_COMMENT_COUNT = 3'd5;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DROP_EMPTY = 3'd6;

  localparam logic [SLOTS_WIDTH-1:0] SEPARATOR_SLOTS_RESET = 32'd44;
  localparam logic [COUNT_WIDTH-1:0] SEPARATOR_COUNT_RESET = 3'd1;

  typedef struct packed {
    logic [SLOTS_WIDTH-1:0] separator_slots;
    logic [COUNT_WIDTH-1:0] separator_count;
    logic [SLOTS_WIDTH-1:0] quote_slots;
    logic [COUNT_WIDTH-1:0] quote_count;
    logic [SLOTS_WIDTH-1:0] comment_slots;
    logic [COUNT_WIDTH-1:0] comment_count;
  } char_sets_t;

  typedef struct packed {
    logic is_separator;
    logic is_comment;
    logic is_quote;
  } char_class_t;

endpackage

### rtl/qfs_classify.sv
module qfs_classify #(
  parameter int CHAR_SLOTS = qfs_pkg::CHAR_SLOTS_DEFAULT
) (
  input  logic [qfs_pkg::CHAR_WIDTH-1:0] text_char,
  input  qfs_pkg::char_sets_t            sets,
  output qfs_pkg::char_class_t           char_class
);
  import qfs_pkg::*;

  logic [REG_SLOTS-1:0] sep_hit;
  logic [REG_SLOTS-1:0] cmt_hit;
  logic [REG_SLOTS-1:0] quo_hit;

  // A slot takes part only below both its set's count and the slot limit.
  for (genvar i = 0; i < REG_SLOTS; i++) begin : g_slot
    localparam logic [COUNT_WIDTH-1:0] SLOT_NUM = COUNT_WIDTH'(i);
    localparam bit SLOT_OK = (i < CHAR_SLOTS);

    assign sep_hit[i] = SLOT_OK && (SLOT_NUM < sets.separator_count)
        && (sets.separator_slots[i*CHAR_WIDTH +: CHAR_WIDTH] == text_char);
    assign cmt_hit[i] = SLOT_OK && (SLOT_NUM < sets.comment_count)
        && (sets.comment_slots[i*CHAR_WIDTH +: CHAR_WIDTH] == text_char);
    assign quo_hit[i] = SLOT_OK && (SLOT_NUM < sets.quote_count)
        && (sets.quote_slots[i*CHAR_WIDTH +: CHAR_WIDTH] == text_char);
  end

  assign char_class.is_separator = |sep_hit;
  assign char_class.is_comment = |cmt_hit;
  assign char_class.is_quote = |quo_hit;

endmodule

### rtl/quoted_field_splitter_unit.sv
// Splits a text line, one character word per cycle and closed by an
// end-of-line word, into a stream of field characters, field-end marks and a
// line-end mark. Each input word is taken into an input register and
// classified against the separator, comment and quote slots. Its result, if
// any, moves into an output register once that register is empty or its
// result is taken. One word is accepted every cycle unless a result waits
// under out_stall with the input register also full. Words that yield no
// result (quote marks, commented text, dropped empty fields) simply vanish.
// Configuration writes must only be issued while no word is in flight.
module quoted_field_splitter_unit #(
  parameter int CHAR_SLOTS = qfs_pkg::CHAR_SLOTS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [qfs_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [qfs_pkg::SLOTS_WIDTH-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [qfs_pkg::CHAR_WIDTH-1:0]     text_char,
  input  logic                               end_of_line,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [qfs_pkg::CHAR_WIDTH-1:0]     out_char,
  output logic                               char_valid,
  output logic                               field_done,
  output logic                               line_done
);
  import qfs_pkg::*;

  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_QUOTED = 2'd1;
  localparam logic [1:0] MODE_COMMENT = 2'd2;

  char_sets_t sets;
  logic       drop_empty;

  logic                  s1_valid;
  logic [CHAR_WIDTH-1:0] s1_char;
  logic                  s1_eol;

  logic [1:0]            scan_mode, scan_mode_next;
  logic [CHAR_WIDTH-1:0] open_quote, open_quote_next;
  logic                  field_nonempty, field_nonempty_next;

  logic                  res_valid;
  logic [CHAR_WIDTH-1:0] res_char;
  logic                  res_char_valid;
  logic                  res_field_done;
  logic                  res_line_done;

  logic        advance;
  logic        s1_load;
  char_class_t char_class;

  assign advance = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;
  // The input register refills whenever it is empty or its word moves on.
  assign s1_load = !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      sets.separator_slots <= SEPARATOR_SLOTS_RESET;
      sets.separator_count <= SEPARATOR_COUNT_RESET;
      sets.quote_slots <= '0;
      sets.quote_count <= '0;
      sets.comment_slots <= '0;
      sets.comment_count <= '0;
      drop_empty <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SEPARATOR_SLOTS: sets.separator_slots <= cfg_data;
        REG_SEPARATOR_COUNT: sets.separator_count <= cfg_data[COUNT_WIDTH-1:0];
        REG_QUOTE_SLOTS:     sets.quote_slots <= cfg_data;
        REG_QUOTE_COUNT:     sets.quote_count <= cfg_data[COUNT_WIDTH-1:0];
        REG_COMMENT_SLOTS:   sets.comment_slots <= cfg_data;
        REG_COMMENT_COUNT:   sets.comment_count <= cfg_data[COUNT_WIDTH-1:0];
        REG_DROP_EMPTY:      drop_empty <= cfg_data[0];
        default: ;
      endcase
    end
  end

  qfs_classify #(
    .CHAR_SLOTS(CHAR_SLOTS)
  ) u_classify (
    .text_char (s1_char),
    .sets      (sets),
    .char_class(char_class)
  );

  always_comb begin
    scan_mode_next = scan_mode;
    open_quote_next = open_quote;
    field_nonempty_next = field_nonempty;
    res_valid = 1'b0;
    res_char = '0;
    res_char_valid = 1'b0;
    res_field_done = 1'b0;
    res_line_done = 1'b0;

    if (s1_eol) begin
      res_valid = 1'b1;
      res_field_done = field_nonempty || !drop_empty;
      res_line_done = 1'b1;
      scan_mode_next = MODE_NORMAL;
      open_quote_next = '0;
      field_nonempty_next = 1'b0;
    end else begin
      case (scan_mode)
        MODE_QUOTED: begin
          if (s1_char == open_quote) begin
            scan_mode_next = MODE_NORMAL;
            open_quote_next = '0;
          end else begin
            field_nonempty_next = 1'b1;
            res_valid = 1'b1;
            res_char = s1_char;
            res_char_valid = 1'b1;
          end
        end
        MODE_NORMAL: begin
          if (char_class.is_separator) begin
            field_nonempty_next = 1'b0;
            res_valid = field_nonempty || !drop_empty;
            res_field_done = 1'b1;
          end else if (char_class.is_comment) begin
            scan_mode_next = MODE_COMMENT;
          end else if (char_class.is_quote) begin
            scan_mode_next = MODE_QUOTED;
            open_quote_next = s1_char;
          end else begin
            field_nonempty_next = 1'b1;
            res_valid = 1'b1;
            res_char = s1_char;
            res_char_valid = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      scan_mode <= MODE_NORMAL;
      open_quote <= '0;
      field_nonempty <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= s1_valid && res_valid;
        if (s1_valid) begin
          scan_mode <= scan_mode_next;
          open_quote <= open_quote_next;
          field_nonempty <= field_nonempty_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_char <= text_char;
      s1_eol <= end_of_line;
    end
    if (advance) begin
      out_char <= res_char;
      char_valid <= res_char_valid;
      field_done <= res_field_done;
      line_done <= res_line_done;
    end
  end

endmodule
